// ===== rtl/i2c_master_bit_engine_unit_defines.svh =====
// Assertion macros shared by the I2C master bit engine RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication check, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CHK_IMPLY(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/i2cmbe_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
// No dependencies; imported by every module of the block.
package i2cmbe_pkg;

  // Reset values of the configuration registers.
  localparam logic [15:0] LONG_DELAY_RESET  = 16'd5;
  localparam logic [15:0] SHORT_DELAY_RESET = 16'd4;
  localparam logic [7:0]  POLL_LIMIT_RESET  = 8'd250;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LONG_DELAY  = 2'd0;
  localparam logic [1:0] CFG_SHORT_DELAY = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

  // Bits in one byte transfer.
  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [3:0] LAST_BIT  = 4'd7;

  // Mode code with no meaning; treated like no command.
  localparam logic [2:0] MODE_RSVD = 3'd7;

  // Queue geometry, shared by the tick queue and the result queue.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Command classes; codes match the mode field.
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ      = 3'd4,
    CMD_WAIT_ACK  = 3'd5,
    CMD_SEND_ACK  = 3'd6
  } cmd_t;

  // Bus sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_RD_HIGH,
    PH_RD_LOW,
    PH_ACK_HI,
    PH_ACK_LO,
    PH_SA_HIGH,
    PH_SA_LOW
  } phase_t;

  // One classified tick as it travels from the front to the engine.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_byte;
    logic       ack_level;
    logic       sda_sample;
  } tick_t;

  // One result word.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       no_ack;
  } res_t;

  // Handshake between a queue and its consumer.
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } tick_head_t;

endpackage

// ===== rtl/i2cmbe_front.sv =====
// Front end: decodes the mode field of each word and queues the tick.
// Depends on i2cmbe_pkg.
module i2cmbe_front
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_write_byte,
  input  logic       in_ack_level,
  input  logic       in_sda_sample,
  output tick_head_t head_o,
  input  logic       pop_i
);

  tick_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;
  tick_t              tick_in;

  // Classify the incoming word; the undefined mode code carries no command.
  always_comb begin
    tick_in.cmd        = (in_mode == MODE_RSVD) ? CMD_NONE : cmd_t'(in_mode);
    tick_in.write_byte = in_write_byte;
    tick_in.ack_level  = in_ack_level;
    tick_in.sda_sample = in_sda_sample;
  end

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop_i && (cnt_r != '0);

  assign head_o.valid = (cnt_r != '0);
  assign head_o.tick  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= tick_in;
    end
  end

endmodule

// ===== rtl/i2cmbe_back.sv =====
// Back end: SCL/SDA sequencer, one queued tick per cycle when not stalled.
// Depends on i2cmbe_pkg and the assertion macro header.
`include "i2c_master_bit_engine_unit_defines.svh"

module i2cmbe_back
  import i2cmbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  tick_head_t  head_i,
  output logic        pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output res_t        res_o
);

  // Configuration registers.
  logic [15:0] long_delay_r, short_delay_r;
  logic [7:0]  poll_limit_r;

  // Sequencer state.
  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drive_r, drive_nxt;
  logic        timeout_r, timeout_nxt;
  logic [7:0]  last_read_r, last_read_nxt;
  logic        done_nxt;

  logic        step;
  logic        is_idle;
  logic        delay_zero;
  logic [15:0] hold_long, hold_short;
  tick_t       tk;

  assign tk         = head_i.tick;
  assign step       = head_i.valid && !res_full_i;
  assign pop_o      = step;
  assign res_push_o = step;

  assign is_idle    = (phase_r == PH_IDLE);
  assign delay_zero = (delay_r == '0);

  // A segment counts the tick that enters it, so load the delay minus one.
  assign hold_long  = (long_delay_r != '0) ? long_delay_r - 16'd1 : '0;
  assign hold_short = (short_delay_r != '0) ? short_delay_r - 16'd1 : '0;

  // Configuration writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_delay_r  <= LONG_DELAY_RESET;
      short_delay_r <= SHORT_DELAY_RESET;
      poll_limit_r  <= POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LONG_DELAY) begin
        long_delay_r <= cfg_wdata;
      end
      if (cfg_index == CFG_SHORT_DELAY) begin
        short_delay_r <= cfg_wdata;
      end
      if (cfg_index == CFG_POLL_LIMIT) begin
        poll_limit_r <= cfg_wdata[7:0];
      end
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (is_idle) begin
      unique case (tk.cmd)
        CMD_START:    phase_nxt = PH_START_A;
        CMD_STOP:     phase_nxt = PH_STOP_A;
        CMD_WRITE:    phase_nxt = PH_WR_LOW;
        CMD_READ:     phase_nxt = PH_RD_HIGH;
        CMD_WAIT_ACK: phase_nxt = PH_ACK_HI;
        CMD_SEND_ACK: phase_nxt = PH_SA_HIGH;
        default:      phase_nxt = PH_IDLE;
      endcase
    end else if (delay_zero) begin
      unique case (phase_r)
        PH_START_A: phase_nxt = PH_START_B;
        PH_STOP_A:  phase_nxt = PH_STOP_B;
        PH_STOP_B:  phase_nxt = PH_STOP_C;
        PH_WR_LOW:  phase_nxt = (bit_count_r >= BYTE_BITS) ? PH_IDLE : PH_WR_HIGH;
        PH_WR_HIGH: phase_nxt = PH_WR_LOW;
        PH_RD_HIGH: phase_nxt = PH_RD_LOW;
        PH_RD_LOW:  phase_nxt = (bit_count_r >= BYTE_BITS) ? PH_IDLE : PH_RD_HIGH;
        PH_ACK_HI: begin
          if (!tk.sda_sample) begin
            phase_nxt = PH_ACK_LO;
          end else if (poll_r >= poll_limit_r) begin
            phase_nxt = PH_STOP_A;
          end
        end
        PH_SA_HIGH: phase_nxt = PH_SA_LOW;
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Line levels, counters and data registers.
  always_comb begin
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    delay_nxt     = delay_r;
    poll_nxt      = poll_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    drive_nxt     = drive_r;
    timeout_nxt   = timeout_r;
    last_read_nxt = last_read_r;
    done_nxt      = 1'b0;
    if (is_idle) begin
      unique case (tk.cmd)
        CMD_START: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          drive_nxt = 1'b1;
          delay_nxt = hold_long;
        end
        CMD_STOP: begin
          sda_nxt   = 1'b0;
          drive_nxt = 1'b1;
          delay_nxt = '0;
        end
        CMD_WRITE: begin
          scl_nxt       = 1'b0;
          shift_nxt     = tk.write_byte;
          bit_count_nxt = '0;
          sda_nxt       = tk.write_byte[7];
          drive_nxt     = 1'b1;
          delay_nxt     = hold_short;
        end
        CMD_READ: begin
          scl_nxt       = 1'b1;
          drive_nxt     = 1'b0;
          sda_nxt       = 1'b1;
          shift_nxt     = '0;
          bit_count_nxt = '0;
          delay_nxt     = hold_short;
        end
        CMD_WAIT_ACK: begin
          scl_nxt     = 1'b1;
          drive_nxt   = 1'b0;
          sda_nxt     = 1'b1;
          poll_nxt    = '0;
          timeout_nxt = 1'b0;
          delay_nxt   = hold_short;
        end
        CMD_SEND_ACK: begin
          drive_nxt = 1'b1;
          sda_nxt   = tk.ack_level;
          scl_nxt   = 1'b1;
          delay_nxt = hold_long;
        end
        default: begin
          done_nxt = 1'b0;
        end
      endcase
    end else if (!delay_zero) begin
      delay_nxt = delay_r - 16'd1;
    end else begin
      unique case (phase_r)
        PH_START_A: begin
          sda_nxt   = 1'b0;
          delay_nxt = hold_long;
        end
        PH_START_B: begin
          scl_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
        PH_STOP_A: begin
          scl_nxt   = 1'b1;
          delay_nxt = hold_long;
        end
        PH_STOP_B: begin
          sda_nxt   = 1'b1;
          delay_nxt = hold_long;
        end
        PH_WR_LOW: begin
          if (bit_count_r >= BYTE_BITS) begin
            done_nxt = 1'b1;
          end else begin
            scl_nxt   = 1'b1;
            delay_nxt = hold_short;
          end
        end
        PH_WR_HIGH: begin
          // Shift to the next bit; after the last bit SDA keeps its level.
          scl_nxt       = 1'b0;
          bit_count_nxt = bit_count_r + 4'd1;
          shift_nxt     = {shift_r[6:0], 1'b0};
          if (bit_count_r < LAST_BIT) begin
            sda_nxt = shift_r[6];
          end
          delay_nxt = hold_short;
        end
        PH_RD_HIGH: begin
          shift_nxt     = {shift_r[6:0], tk.sda_sample};
          bit_count_nxt = bit_count_r + 4'd1;
          scl_nxt       = 1'b0;
          delay_nxt     = hold_short;
        end
        PH_RD_LOW: begin
          if (bit_count_r >= BYTE_BITS) begin
            last_read_nxt = shift_r;
            done_nxt      = 1'b1;
          end else begin
            scl_nxt   = 1'b1;
            delay_nxt = hold_short;
          end
        end
        PH_ACK_HI: begin
          // Low SDA is the acknowledge; too many high polls issue a stop.
          if (!tk.sda_sample) begin
            scl_nxt   = 1'b0;
            delay_nxt = hold_short;
          end else if (poll_r >= poll_limit_r) begin
            timeout_nxt = 1'b1;
            sda_nxt     = 1'b0;
            drive_nxt   = 1'b1;
            delay_nxt   = '0;
          end else begin
            poll_nxt = poll_r + 8'd1;
          end
        end
        PH_SA_HIGH: begin
          scl_nxt   = 1'b0;
          delay_nxt = hold_long;
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  // Result word shows the levels after this tick's update.
  always_comb begin
    res_o.scl_level = scl_nxt;
    res_o.sda_level = drive_nxt ? sda_nxt : 1'b1;
    res_o.sda_drive = drive_nxt;
    res_o.busy_res  = (phase_nxt != PH_IDLE);
    res_o.done_res  = done_nxt;
    res_o.read_byte = last_read_nxt;
    res_o.no_ack    = timeout_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= '0;
      shift_r     <= '0;
      delay_r     <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drive_r     <= 1'b1;
      timeout_r   <= 1'b0;
      last_read_r <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      delay_r     <= delay_nxt;
      poll_r      <= poll_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      drive_r     <= drive_nxt;
      timeout_r   <= timeout_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  // The idle phase is only reached with the segment counter drained.
  `CHK_IMPLY(a_idle_no_delay, clk, rst_n, phase_r == PH_IDLE, delay_r == '0)
  // The bit counter never runs past one byte.
  `CHK_IMPLY(a_bit_bound, clk, rst_n, 1'b1, bit_count_r <= BYTE_BITS)
  // A finishing tick leaves the sequencer idle.
  `CHK_NEXT(a_done_idle, clk, rst_n, step && done_nxt, phase_r == PH_IDLE)
  // The no-acknowledge flag is only raised by the acknowledge poll.
  `CHK_IMPLY(a_timeout_src, clk, rst_n, $rose(timeout_r), $past(phase_r) == PH_ACK_HI)

endmodule

// ===== rtl/i2cmbe_outq.sv =====
// Result queue: holds finished result words until the consumer pops them.
// Depends on i2cmbe_pkg.
module i2cmbe_outq
  import i2cmbe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  input  logic pop,
  output logic empty,
  output res_t res_o
);

  res_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full_o  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop && !empty;
  assign res_o   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= res_i;
    end
  end

endmodule

// ===== rtl/i2c_master_bit_engine_unit.sv =====
// I2C master bit engine. Every word pushed is one timing tick: it carries the
// sampled SDA level and, while the engine is idle, a command (start, stop,
// write byte, read byte, wait for acknowledge, send acknowledge). Every tick
// yields exactly one result word with the SCL level, SDA level and drive,
// busy, a one-tick done pulse, the last read byte and the no-acknowledge flag.
// Segment lengths come from the long and short delay registers; an
// acknowledge wait that sees too many high polls issues a stop and sets
// no-acknowledge. The engine accepts one tick per clock and turns out one
// result per clock unless a full queue or a missing tick stalls it. The
// sequencer sets the rate; registered two-entry queues in front of and behind
// it absorb stalls. The user must write configuration only while no tick
// is outstanding; the block itself does not enforce this.
module i2c_master_bit_engine_unit
  import i2cmbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_write_byte,
  input  logic        in_ack_level,
  input  logic        in_sda_sample,
  output logic        empty,
  input  logic        pop,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_sda_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_read_byte,
  output logic        out_no_ack
);

  tick_head_t head;
  logic       tick_pop;
  logic       res_full;
  logic       res_push;
  res_t       res_eng;
  res_t       res_out;

  // Decode and queue incoming ticks.
  i2cmbe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_mode       (in_mode),
    .in_write_byte (in_write_byte),
    .in_ack_level  (in_ack_level),
    .in_sda_sample (in_sda_sample),
    .head_o        (head),
    .pop_i         (tick_pop)
  );

  // Bus sequencer.
  i2cmbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_i     (head),
    .pop_o      (tick_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_eng)
  );

  // Result queue toward the consumer.
  i2cmbe_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (res_push),
    .res_i  (res_eng),
    .full_o (res_full),
    .pop    (pop),
    .empty  (empty),
    .res_o  (res_out)
  );

  assign out_scl_level = res_out.scl_level;
  assign out_sda_level = res_out.sda_level;
  assign out_sda_drive = res_out.sda_drive;
  assign out_busy_res  = res_out.busy_res;
  assign out_done_res  = res_out.done_res;
  assign out_read_byte = res_out.read_byte;
  assign out_no_ack    = res_out.no_ack;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the I2C master bit engine: drives timing ticks through the
// queue-style input, predicts every result word and checks it field by field.
// Depends on rtl/i2cmbe_pkg.sv and rtl/i2c_master_bit_engine_unit.sv.
module tb_top;
  import i2cmbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned RANDOM_TICKS = 540;
  localparam int unsigned REPORT_LIMIT = 10;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        push;
  logic        full;
  logic [2:0]  in_mode;
  logic [7:0]  in_write_byte;
  logic        in_ack_level;
  logic        in_sda_sample;
  logic        empty;
  logic        pop;
  logic        out_scl_level;
  logic        out_sda_level;
  logic        out_sda_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_read_byte;
  logic        out_no_ack;

  i2c_master_bit_engine_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .full          (full),
    .in_mode       (in_mode),
    .in_write_byte (in_write_byte),
    .in_ack_level  (in_ack_level),
    .in_sda_sample (in_sda_sample),
    .empty         (empty),
    .pop           (pop),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_sda_drive (out_sda_drive),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_read_byte (out_read_byte),
    .out_no_ack    (out_no_ack)
  );

  // Predicted bus engine state and its configuration copy.
  phase_t      bus_phase = PH_IDLE;
  logic [3:0]  bus_bits = '0;
  logic [7:0]  bus_shift = '0;
  logic [15:0] seg_count = '0;
  logic [7:0]  poll_count = '0;
  logic        bus_scl = 1'b1;
  logic        bus_sda = 1'b1;
  logic        bus_drive = 1'b1;
  logic        bus_no_ack = 1'b0;
  logic        bus_done = 1'b0;
  logic [7:0]  read_latch = '0;
  logic [15:0] long_dly = LONG_DELAY_RESET;
  logic [15:0] short_dly = SHORT_DELAY_RESET;
  logic [7:0]  poll_lim = POLL_LIMIT_RESET;

  res_t expected_bus_q[$];

  int unsigned feed_idle_pct = 35;
  int unsigned sink_idle_pct = 35;
  int unsigned stall_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cmds_accepted = 0;
  int unsigned ack_timeouts = 0;
  int unsigned input_stalls = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Segment length counts the entering tick, so the counter holds one less.
  function automatic logic [15:0] seg_len(input logic [15:0] d);
    return (d == 16'd0) ? 16'd0 : d - 16'd1;
  endfunction

  function automatic void finish_cmd();
    bus_phase = PH_IDLE;
    bus_done = 1'b1;
  endfunction

  // Stop lowers SDA first, then raises SCL, then releases SDA high.
  function automatic void begin_stop();
    bus_sda = 1'b0;
    bus_drive = 1'b1;
    bus_phase = PH_STOP_A;
    seg_count = '0;
  endfunction

  // Advance the predicted engine by one tick and return the word it yields.
  function automatic res_t predict_bus_tick(input logic [2:0] mode, input logic [7:0] wbyte,
                                            input logic ackl, input logic sda_in);
    res_t r;
    bus_done = 1'b0;
    if (bus_phase == PH_IDLE) begin
      if (mode != CMD_NONE && mode != MODE_RSVD) cmds_accepted++;
      case (mode)
        CMD_START: begin
          bus_scl = 1'b1; bus_sda = 1'b1; bus_drive = 1'b1;
          bus_phase = PH_START_A; seg_count = seg_len(long_dly);
        end
        CMD_STOP: begin_stop();
        CMD_WRITE: begin
          bus_scl = 1'b0; bus_shift = wbyte; bus_bits = '0;
          bus_sda = wbyte[7]; bus_drive = 1'b1;
          bus_phase = PH_WR_LOW; seg_count = seg_len(short_dly);
        end
        CMD_READ: begin
          bus_scl = 1'b1; bus_drive = 1'b0; bus_sda = 1'b1;
          bus_shift = '0; bus_bits = '0;
          bus_phase = PH_RD_HIGH; seg_count = seg_len(short_dly);
        end
        CMD_WAIT_ACK: begin
          bus_scl = 1'b1; bus_drive = 1'b0; bus_sda = 1'b1;
          poll_count = '0; bus_no_ack = 1'b0;
          bus_phase = PH_ACK_HI; seg_count = seg_len(short_dly);
        end
        CMD_SEND_ACK: begin
          bus_drive = 1'b1; bus_sda = ackl; bus_scl = 1'b1;
          bus_phase = PH_SA_HIGH; seg_count = seg_len(long_dly);
        end
        default: ;
      endcase
    end else if (seg_count != 16'd0) begin
      seg_count--;
    end else begin
      case (bus_phase)
        PH_START_A: begin
          bus_sda = 1'b0; bus_phase = PH_START_B; seg_count = seg_len(long_dly);
        end
        PH_START_B: begin
          bus_scl = 1'b0; finish_cmd();
        end
        PH_STOP_A: begin
          bus_scl = 1'b1; bus_phase = PH_STOP_B; seg_count = seg_len(long_dly);
        end
        PH_STOP_B: begin
          bus_sda = 1'b1; bus_phase = PH_STOP_C; seg_count = seg_len(long_dly);
        end
        PH_WR_LOW: begin
          if (bus_bits >= BYTE_BITS) begin
            finish_cmd();
          end else begin
            bus_scl = 1'b1; bus_phase = PH_WR_HIGH; seg_count = seg_len(short_dly);
          end
        end
        PH_WR_HIGH: begin
          bus_scl = 1'b0;
          bus_bits++;
          bus_shift = bus_shift << 1;
          if (bus_bits < BYTE_BITS) bus_sda = bus_shift[7];
          bus_phase = PH_WR_LOW; seg_count = seg_len(short_dly);
        end
        PH_RD_HIGH: begin
          bus_shift = {bus_shift[6:0], sda_in};
          bus_bits++;
          bus_scl = 1'b0;
          bus_phase = PH_RD_LOW; seg_count = seg_len(short_dly);
        end
        PH_RD_LOW: begin
          if (bus_bits >= BYTE_BITS) begin
            read_latch = bus_shift; finish_cmd();
          end else begin
            bus_scl = 1'b1; bus_phase = PH_RD_HIGH; seg_count = seg_len(short_dly);
          end
        end
        PH_ACK_HI: begin
          if (!sda_in) begin
            bus_scl = 1'b0; bus_phase = PH_ACK_LO; seg_count = seg_len(short_dly);
          end else if (poll_count >= poll_lim) begin
            // Too many high polls: flag it and release the bus with a stop.
            bus_no_ack = 1'b1; ack_timeouts++; begin_stop();
          end else begin
            poll_count++;
          end
        end
        PH_SA_HIGH: begin
          bus_scl = 1'b0; bus_phase = PH_SA_LOW; seg_count = seg_len(long_dly);
        end
        default: finish_cmd();
      endcase
    end
    r.scl_level = bus_scl;
    r.sda_level = bus_drive ? bus_sda : 1'b1;
    r.sda_drive = bus_drive;
    r.busy_res  = (bus_phase != PH_IDLE);
    r.done_res  = bus_done;
    r.read_byte = read_latch;
    r.no_ack    = bus_no_ack;
    return r;
  endfunction

  function automatic logic line_level(input int unsigned high_pct);
    return ($urandom_range(99) < high_pct);
  endfunction

  // Offer one tick word; entered and left at a falling edge with push held.
  task automatic send_tick(input logic [2:0] mode, input logic [7:0] wbyte,
                           input logic ackl, input logic sda_in);
    while ($urandom_range(99) < feed_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push          <= 1'b1;
    in_mode       <= mode;
    in_write_byte <= wbyte;
    in_ack_level  <= ackl;
    in_sda_sample <= sda_in;
    do @(posedge clk); while (full);
    expected_bus_q.push_back(predict_bus_tick(mode, wbyte, ackl, sda_in));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Issue a command on an idle engine and tick it through to completion.
  // Ticks while busy carry random commands, which the engine must ignore.
  task automatic run_command(input logic [2:0] mode, input logic [7:0] wbyte,
                             input logic ackl, input int unsigned sda_high_pct);
    send_tick(mode, wbyte, ackl, line_level(sda_high_pct));
    while (bus_phase != PH_IDLE)
      send_tick(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                line_level(sda_high_pct));
  endtask

  // Stop sending and wait until every expected word has been checked.
  task automatic wait_results_drained();
    push <= 1'b0;
    do @(negedge clk); while (expected_bus_q.size() != 0);
  endtask

  // Write all three registers while nothing is outstanding.
  task automatic write_config(input logic [15:0] l, input logic [15:0] s,
                              input logic [7:0] p);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LONG_DELAY;
    cfg_wdata <= l;
    @(negedge clk);
    cfg_index <= CFG_SHORT_DELAY;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_index <= CFG_POLL_LIMIT;
    cfg_wdata <= {8'h00, p};
    @(negedge clk);
    cfg_we    <= 1'b0;
    long_dly  = l;
    short_dly = s;
    poll_lim  = p;
    @(negedge clk);
  endtask

  // One bus transfer: start, addressed writes with acknowledge waits, reads
  // with sent acknowledges, stop. A share of the traffic is loose noise.
  task automatic random_transfer();
    int unsigned pick;
    int unsigned ack_pcts[4] = '{0, 60, 85, 100};
    if ($urandom_range(99) < 15) begin
      pick = $urandom_range(7);
      if (pick == CMD_NONE || pick == MODE_RSVD)
        repeat ($urandom_range(1, 4))
          send_tick(3'(pick), 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      else
        run_command(3'(pick), 8'($urandom_range(255)), 1'($urandom_range(1)),
                    $urandom_range(100));
      return;
    end
    run_command(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
    repeat ($urandom_range(1, 3)) begin
      run_command(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
      run_command(CMD_WAIT_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  ack_pcts[$urandom_range(3)]);
      // A timed-out acknowledge already released the bus.
      if (bus_no_ack) return;
    end
    repeat ($urandom_range(0, 2)) begin
      run_command(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
      run_command(CMD_SEND_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
    end
    run_command(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
  endtask

  // Every command once under the reset configuration.
  task automatic test_reset_config_commands();
    run_command(CMD_START, 8'h00, 1'b0, 50);
    run_command(CMD_WRITE, 8'hA5, 1'b0, 50);
    run_command(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
    run_command(CMD_READ, 8'h00, 1'b0, 50);
    run_command(CMD_SEND_ACK, 8'h00, 1'b1, 50);
    run_command(CMD_STOP, 8'h00, 1'b0, 50);
  endtask

  // Byte extremes, reserved mode, acknowledge timeout and its clearing,
  // then zero delays and a zero poll limit.
  task automatic test_directed_corners();
    write_config(16'd1, 16'd1, 8'd2);
    run_command(CMD_WRITE, 8'h00, 1'b0, 50);
    run_command(CMD_WRITE, 8'hFF, 1'b1, 50);
    run_command(CMD_READ, 8'h00, 1'b0, 100);
    run_command(CMD_READ, 8'hFF, 1'b1, 0);
    run_command(CMD_SEND_ACK, 8'h00, 1'b0, 50);
    send_tick(MODE_RSVD, 8'hFF, 1'b1, 1'b1);
    send_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);
    run_command(CMD_WAIT_ACK, 8'h00, 1'b0, 100);
    run_command(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
    run_command(CMD_STOP, 8'h00, 1'b0, 50);
    write_config(16'd0, 16'd0, 8'd0);
    run_command(CMD_START, 8'h00, 1'b0, 50);
    run_command(CMD_WAIT_ACK, 8'h00, 1'b0, 100);
    run_command(CMD_WRITE, 8'h5A, 1'b0, 50);
    run_command(CMD_SEND_ACK, 8'h00, 1'b1, 50);
    run_command(CMD_STOP, 8'h00, 1'b0, 50);
  endtask

  // Receiver holds off while the sender keeps offering, so both queues
  // fill and push stalls; then the sender pauses until all words are back.
  task automatic test_backpressure();
    write_config(16'd1, 16'd1, 8'd3);
    feed_idle_pct = 0;
    stall_cycles  = 80;
    run_command(CMD_START, 8'h00, 1'b0, 50);
    run_command(CMD_WRITE, 8'($urandom_range(255)), 1'b0, 50);
    run_command(CMD_STOP, 8'h00, 1'b0, 50);
    feed_idle_pct = 35;
    wait_results_drained();
  endtask

  // Random transfers under a spread of delay and poll settings.
  task automatic test_random_traffic();
    int unsigned longs[6]  = '{5, 1, 2, 0, 3, 1};
    int unsigned shorts[6] = '{4, 1, 1, 0, 2, 3};
    int unsigned limits[6] = '{250, 3, 1, 0, 6, 255};
    int unsigned stop_at;
    for (int i = 0; i < 6; i++) begin
      write_config(16'(longs[i]), 16'(shorts[i]), 8'(limits[i]));
      stop_at = ticks_sent + RANDOM_TICKS / 6;
      while (ticks_sent < stop_at) random_transfer();
    end
    write_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                 8'($urandom_range(0, 8)));
    stop_at = ticks_sent + RANDOM_TICKS / 6;
    while (ticks_sent < stop_at) random_transfer();
  endtask

  // Long delay segments and the full-scale poll limit, run back to back
  // with no idling.
  task automatic test_delay_extremes();
    feed_idle_pct = 0;
    sink_idle_pct = 0;
    write_config(16'd24, 16'd1, 8'd255);
    run_command(CMD_START, 8'h00, 1'b0, 50);
    write_config(16'd1, 16'd24, 8'd255);
    run_command(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
    write_config(16'd1, 16'd1, 8'd255);
    run_command(CMD_WAIT_ACK, 8'h00, 1'b0, 100);
    feed_idle_pct = 35;
    sink_idle_pct = 35;
  endtask

  // Result side: random pop, with a counted hold-off when one is requested.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cycles > 0) begin
        stall_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("mismatch in %s of word %0d: expected %0h, got %0h",
                 name, words_checked, want, got);
    end
  endtask

  // Compare each popped word with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (expected_bus_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result word with nothing expected at cycle %0d", cycle_count);
      end else begin
        want = expected_bus_q.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(out_scl_level));
        check_field("sda_level", 8'(want.sda_level), 8'(out_sda_level));
        check_field("sda_drive", 8'(want.sda_drive), 8'(out_sda_drive));
        check_field("busy_res", 8'(want.busy_res), 8'(out_busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_done_res));
        check_field("read_byte", want.read_byte, out_read_byte);
        check_field("no_ack", 8'(want.no_ack), 8'(out_no_ack));
      end
      words_checked++;
    end
  end

  // Stall statistics and the run limit.
  always @(posedge clk) begin
    if (push && full) input_stalls++;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", expected_bus_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_LONG_DELAY;
    cfg_wdata     = '0;
    push          = 1'b0;
    in_mode       = CMD_NONE;
    in_write_byte = '0;
    in_ack_level  = 1'b0;
    in_sda_sample = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_config_commands();
    test_directed_corners();
    test_backpressure();
    test_random_traffic();
    test_delay_extremes();

    wait_results_drained();
    repeat (20) @(negedge clk);

    $display("ran %0d ticks with %0d commands, %0d acknowledge timeouts",
             ticks_sent, cmds_accepted, ack_timeouts);
    $display("checked %0d words; input stalled %0d cycles; %0d mismatches",
             words_checked, input_stalls, mismatch_count);
    if (mismatch_count == 0 && expected_bus_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
